// File: src/mhd_pkg.sv
// ----------------------------------------------------------------------------
// mhd_pkg: shared types and helpers for the marker id decoder
// Status codes, grid types and the grid reshaping functions.
// ----------------------------------------------------------------------------
package mhd_pkg;

   localparam int unsigned CellW  = 49;
   localparam int unsigned Side   = 5;
   localparam int unsigned InnerW = Side * Side;
   localparam int unsigned NumRot = 4;

   typedef logic [1:0] status_type;
   localparam status_type ST_DECODED = 2'd0;
   localparam status_type ST_BORDER  = 2'd1;
   localparam status_type ST_DIST    = 2'd2;

   typedef logic [InnerW-1:0] grid_type;    // bit y*5+x is row y, column x
   typedef logic [2:0]        rdist_type;   // least distance of one row, 0..5
   typedef logic [4:0]        score_type;   // sum over five rows, 0..25
   typedef rdist_type [Side-1:0] row_dists_type;

   // Mask of the outer ring of the 7x7 grid.
   function automatic logic [CellW-1:0] border_mask();
      logic [CellW-1:0] m;
      m = '0;
      for (int y = 0; y < 7; y++) begin
         for (int x = 0; x < 7; x++) begin
            if (y == 0 || y == 6 || x == 0 || x == 6) begin
               m[y*7+x] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   // Pull the inner 5x5 cells out of the 7x7 grid.
   function automatic grid_type inner_grid(logic [CellW-1:0] c);
      grid_type g;
      for (int y = 0; y < Side; y++) begin
         for (int x = 0; x < Side; x++) begin
            g[y*Side+x] = c[(y+1)*7+x+1];
         end
      end
      return g;
   endfunction

   // One quarter turn: new cell (i, j) takes old cell (4 - j, i).
   function automatic grid_type quarter_turn(grid_type s);
      grid_type d;
      for (int i = 0; i < Side; i++) begin
         for (int j = 0; j < Side; j++) begin
            d[i*Side+j] = s[(Side-1-j)*Side+i];
         end
      end
      return d;
   endfunction

endpackage

// File: src/mhd_row_dist.sv
// ----------------------------------------------------------------------------
// mhd_row_dist: least codeword distance of each row of one 5x5 grid
// Each row is compared against the four 5-bit codewords; the smallest
// Hamming distance per row is returned.
// ----------------------------------------------------------------------------
module mhd_row_dist
   import mhd_pkg::*;
(
   input  grid_type      grid,
   output row_dists_type dists
);

   // Codewords with column 0 in bit 0.
   localparam logic [4:0] CW0 = 5'b00001;
   localparam logic [4:0] CW1 = 5'b11101;
   localparam logic [4:0] CW2 = 5'b10010;
   localparam logic [4:0] CW3 = 5'b01110;

   function automatic rdist_type pop5(logic [4:0] v);
      rdist_type n;
      n = '0;
      for (int b = 0; b < 5; b++) begin
         n = n + rdist_type'(v[b]);
      end
      return n;
   endfunction

   function automatic rdist_type min2(rdist_type a, rdist_type b);
      return (b < a) ? b : a;
   endfunction

   always_comb begin
      for (int r = 0; r < Side; r++) begin
         dists[r] = min2(min2(pop5(grid[r*Side +: Side] ^ CW0),
                              pop5(grid[r*Side +: Side] ^ CW1)),
                         min2(pop5(grid[r*Side +: Side] ^ CW2),
                              pop5(grid[r*Side +: Side] ^ CW3)));
      end
   end

endmodule

// File: src/marker_id_hamming_decode.sv
// ----------------------------------------------------------------------------
// marker_id_hamming_decode: 5x5 Hamming marker id decoder
// Checks the black border of a 7x7 cell grid, scores four orientations of
// the inner 5x5 cells and returns status, id, rotation and distance.
// ----------------------------------------------------------------------------
// One result per accepted grid. The block is a four-register pipeline:
// input capture and border check, per-row codeword distances, per-orientation
// sums, then best-orientation selection into the output register. A grid can
// be accepted every cycle while the output side does not stall, and its result
// passes through the stage 1, 2 and 3 registers and the output register to
// rsp_valid. A stall on rsp_ready backs up through the stages; each stage keeps
// taking items while it has a free slot.
module marker_id_hamming_decode
   import mhd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CellW-1:0]  req_cell_bits,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [9:0]        rsp_marker_id,
   output logic [1:0]        rsp_rotation,
   output logic [3:0]        rsp_distance
);

   localparam logic [CellW-1:0] BorderMask = border_mask();

   // stage 1: inner cells and border flag
   logic     s1_valid_ff, s1_valid_in;
   grid_type s1_grid_ff;
   logic     s1_border_ff;
   // stage 2: row distances for each orientation
   logic          s2_valid_ff, s2_valid_in;
   grid_type      s2_grid_ff;
   logic          s2_border_ff;
   row_dists_type s2_dists_ff [NumRot];
   // stage 3: orientation scores
   logic      s3_valid_ff, s3_valid_in;
   grid_type  s3_grid_ff;
   logic      s3_border_ff;
   score_type s3_score_ff [NumRot];
   // stage 4: output register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   logic [9:0] id_ff, id_in;
   logic [1:0] rot_ff, rot_in;
   logic [3:0] dist_ff, dist_in;

   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready  = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign s1_valid_in  = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = s4_ready ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- stage 1 ----
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_grid_ff   <= inner_grid(req_cell_bits);
         s1_border_ff <= |(req_cell_bits & BorderMask);
      end
   end

   // ---- stage 2 ----
   grid_type      s1_turn [NumRot];
   row_dists_type s1_dists [NumRot];

   always_comb begin
      s1_turn[0] = s1_grid_ff;
      for (int k = 1; k < NumRot; k++) begin
         s1_turn[k] = quarter_turn(s1_turn[k-1]);
      end
   end

   for (genvar k = 0; k < NumRot; k++) begin : g_rot
      mhd_row_dist u_row_dist (
         .grid  (s1_turn[k]),
         .dists (s1_dists[k])
      );
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_grid_ff   <= s1_grid_ff;
         s2_border_ff <= s1_border_ff;
         s2_dists_ff  <= s1_dists;
      end
   end

   // ---- stage 3 ----
   score_type s2_score [NumRot];

   always_comb begin
      for (int k = 0; k < NumRot; k++) begin
         s2_score[k] = '0;
         for (int r = 0; r < Side; r++) begin
            s2_score[k] = s2_score[k] + score_type'(s2_dists_ff[k][r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_grid_ff   <= s2_grid_ff;
         s3_border_ff <= s2_border_ff;
         s3_score_ff  <= s2_score;
      end
   end

   // ---- stage 4 ----
   grid_type  s3_turn [NumRot];
   score_type best_score;
   logic [1:0] best_k;

   always_comb begin
      s3_turn[0] = s3_grid_ff;
      for (int k = 1; k < NumRot; k++) begin
         s3_turn[k] = quarter_turn(s3_turn[k-1]);
      end

      // strict compare keeps the lowest rotation on a tie
      best_score = s3_score_ff[0];
      best_k     = 2'd0;
      for (int k = 1; k < NumRot; k++) begin
         if (s3_score_ff[k] < best_score) begin
            best_score = s3_score_ff[k];
            best_k     = 2'(k);
         end
      end

      id_in = '0;
      for (int y = 0; y < Side; y++) begin
         id_in[9-2*y] = s3_turn[best_k][y*Side+1];
         id_in[8-2*y] = s3_turn[best_k][y*Side+3];
      end

      if (s3_border_ff) begin
         status_in = ST_BORDER;
         id_in     = '0;
         rot_in    = '0;
         dist_in   = '0;
      end else begin
         rot_in  = best_k;
         dist_in = (best_score > score_type'(15)) ? 4'd15 : best_score[3:0];
         if (best_score == '0) begin
            status_in = ST_DECODED;
         end else begin
            status_in = ST_DIST;
            id_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         status_ff <= status_in;
         id_ff     <= id_in;
         rot_ff    <= rot_in;
         dist_ff   <= dist_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_marker_id = id_ff;
   assign rsp_rotation  = rot_ff;
   assign rsp_distance  = dist_ff;

endmodule

// File: src/mhd_checker.sv
// ----------------------------------------------------------------------------
// mhd_checker: port-level checks for the marker id decoder
// Watches the result channel for consistent field combinations.
// ----------------------------------------------------------------------------
module mhd_checker
   import mhd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [9:0] rsp_marker_id,
   input logic [1:0] rsp_rotation,
   input logic [3:0] rsp_distance
);

   // a rejected grid carries no id, rotation or distance
   a_border_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BORDER |->
         rsp_marker_id == '0 && rsp_rotation == '0 && rsp_distance == '0)
      else $error("border transaction carries nonzero fields");

   a_dist_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIST |->
         rsp_marker_id == '0 && rsp_distance != '0)
      else $error("distance transaction has id or zero distance");

   a_decoded_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DECODED |-> rsp_distance == '0)
      else $error("decoded transaction has nonzero distance");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_DECODED || rsp_status == ST_BORDER ||
                    rsp_status == ST_DIST)
      else $error("undefined status code");

   // hold the result while the consumer stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_marker_id) && $stable(rsp_rotation) && $stable(rsp_distance))
      else $error("result changed while stalled");

endmodule

bind marker_id_hamming_decode mhd_checker u_mhd_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for marker_id_hamming_decode
// Drives 7x7 cell grids through the valid/ready input channel and checks
// every decoded result against a local model of border check, orientation
// scoring and id packing. Four handshake phases vary sender idling and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   import mhd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned PHASE_ITEMS  = 258;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int BORDER_TAPS [8] = '{0, 3, 6, 21, 27, 42, 45, 48};

   typedef struct packed {
      status_type status;
      logic [9:0] marker_id;
      logic [1:0] rotation;
      logic [3:0] distance;
   } decode_type;

   // Expected decodes in acceptance order, checked against the result channel.
   class decode_scoreboard;
      decode_type  expected_q[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned status_seen [3];
      // Codewords, column 0 first.
      bit code_rows [4][5] = '{'{1, 0, 0, 0, 0},
                               '{1, 0, 1, 1, 1},
                               '{0, 1, 0, 0, 1},
                               '{0, 1, 1, 1, 0}};

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // Row as a 5-bit vector, bit x = column x.
      function logic [4:0] codeword_row(int p);
         logic [4:0] r;
         for (int x = 0; x < 5; x++) r[x] = code_rows[p][x];
         return r;
      endfunction

      // New cell (i, j) takes old cell (4 - j, i); bit y*5+x is row y, column x.
      function logic [24:0] turn_inner(logic [24:0] s);
         logic [24:0] d;
         for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
               d[i*5+j] = s[(4-j)*5+i];
            end
         end
         return d;
      endfunction

      function decode_type decode_grid(logic [48:0] cells);
         decode_type  r;
         logic [24:0] turns [4];
         int          score, best_score, best_k, d, row_best;
         logic [9:0]  id;
         bit          white;
         white = 1'b0;
         for (int y = 0; y < 7; y++) begin
            for (int x = 0; x < 7; x++) begin
               if ((y == 0 || y == 6 || x == 0 || x == 6) && cells[y*7+x]) white = 1'b1;
            end
         end
         if (white) begin
            r.status    = ST_BORDER;
            r.marker_id = '0;
            r.rotation  = '0;
            r.distance  = '0;
            return r;
         end
         for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) turns[0][y*5+x] = cells[(y+1)*7+x+1];
         end
         for (int k = 1; k < 4; k++) turns[k] = turn_inner(turns[k-1]);
         best_score = 0;
         best_k     = 0;
         for (int k = 0; k < 4; k++) begin
            score = 0;
            for (int y = 0; y < 5; y++) begin
               row_best = 5;
               for (int p = 0; p < 4; p++) begin
                  d = 0;
                  for (int x = 0; x < 5; x++) begin
                     if (turns[k][y*5+x] != code_rows[p][x]) d++;
                  end
                  if (d < row_best) row_best = d;
               end
               score += row_best;
            end
            // strict compare keeps the lowest rotation on ties
            if (k == 0 || score < best_score) begin
               best_score = score;
               best_k     = k;
            end
         end
         id = '0;
         if (best_score == 0) begin
            for (int y = 0; y < 5; y++) begin
               id = {id[7:0], turns[best_k][y*5+1], turns[best_k][y*5+3]};
            end
         end
         r.status    = (best_score == 0) ? ST_DECODED : ST_DIST;
         r.marker_id = id;
         r.rotation  = best_k[1:0];
         r.distance  = (best_score > 15) ? 4'd15 : best_score[3:0];
         return r;
      endfunction

      function void note_grid(logic [48:0] cells);
         expected_q.push_back(decode_grid(cells));
      endfunction

      function int pending_count();
         return expected_q.size();
      endfunction

      task check_result(decode_type got);
         decode_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending (status %0d)", got.status));
         end else begin
            want = expected_q.pop_front();
            checked++;
            if (got.status < 3) status_seen[got.status]++;
            if (got.status !== want.status)
               report($sformatf("status got %0d, expected %0d", got.status, want.status));
            if (got.marker_id !== want.marker_id)
               report($sformatf("marker_id got %0d, expected %0d",
                                got.marker_id, want.marker_id));
            if (got.rotation !== want.rotation)
               report($sformatf("rotation got %0d, expected %0d",
                                got.rotation, want.rotation));
            if (got.distance !== want.distance)
               report($sformatf("distance got %0d, expected %0d",
                                got.distance, want.distance));
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CellW-1:0]  req_cell_bits = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic [9:0]        rsp_marker_id;
   logic [1:0]        rsp_rotation;
   logic [3:0]        rsp_distance;

   decode_scoreboard  sb = new;
   int unsigned       idle_pct  = 0;
   int unsigned       stall_pct = 0;
   int unsigned       cycles    = 0;
   int unsigned       grids_sent = 0;

   marker_id_hamming_decode uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_bits (req_cell_bits),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_marker_id (rsp_marker_id),
      .rsp_rotation  (rsp_rotation),
      .rsp_distance  (rsp_distance)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_grid(req_cell_bits);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_status, rsp_marker_id, rsp_rotation, rsp_distance});
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // Wrap a 5x5 inner grid in an all-black border.
   function automatic logic [48:0] place_inner(logic [24:0] inner);
      logic [48:0] c;
      c = '0;
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) c[(y+1)*7+x+1] = inner[y*5+x];
      end
      return c;
   endfunction

   function automatic logic [24:0] valid_inner();
      logic [24:0] inner;
      int          turns;
      for (int y = 0; y < 5; y++) inner[y*5 +: 5] = sb.codeword_row($urandom_range(3));
      turns = $urandom_range(3);
      for (int k = 0; k < turns; k++) inner = sb.turn_inner(inner);
      return inner;
   endfunction

   // Well-formed markers for the largest share, some damaged, some noise.
   function automatic logic [48:0] random_grid();
      logic [24:0] inner;
      logic [63:0] raw;
      int          pick, flips;
      pick = $urandom_range(99);
      inner = valid_inner();
      if (pick < 45) begin
         return place_inner(inner);
      end else if (pick < 70) begin
         flips = $urandom_range(3, 1);
         for (int f = 0; f < flips; f++) inner[$urandom_range(24)] ^= 1'b1;
         return place_inner(inner);
      end else if (pick < 85) begin
         return place_inner(25'($urandom));
      end else if (pick < 92) begin
         return place_inner(inner) | (49'd1 << BORDER_TAPS[$urandom_range(7)]);
      end else begin
         raw = {$urandom, $urandom};
         return raw[48:0];
      end
   endfunction

   task automatic send_grid(input logic [48:0] cells);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_bits <= cells;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      grids_sent++;
   endtask

   // Hold the sender until every expected result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   initial begin
      logic [24:0] base;
      logic [24:0] turned;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, rotations, damaged rows, border taps
      send_grid('0);
      send_grid({CellW{1'b1}});
      send_grid(place_inner({25{1'b1}}));
      base = {sb.codeword_row(0), sb.codeword_row(3), sb.codeword_row(2),
              sb.codeword_row(1), sb.codeword_row(0)};
      turned = base;
      for (int k = 0; k < 4; k++) begin
         send_grid(place_inner(turned));
         turned = sb.turn_inner(turned);
      end
      send_grid(place_inner(base ^ 25'd1 << 7));
      send_grid(place_inner(base ^ 25'd1 << 12));
      send_grid(place_inner(base ^ (25'd1 << 2) ^ (25'd1 << 18)));
      for (int t = 0; t < 8; t++) send_grid(place_inner(base) | (49'd1 << BORDER_TAPS[t]));
      send_grid(place_inner(25'h1555555));
      send_grid(place_inner({5{sb.codeword_row(3)}}));

      for (int phase = 0; phase < 4; phase++) begin
         if (phase != 0) drain_results();
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 80; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 80; end
            default: begin idle_pct = 11; stall_pct <= 11; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_grid(random_grid());
      end
      req_valid <= 1'b0;
      stall_pct <= 0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_count() != 0) sb.report("expected results left over");

      $display("covered %0d grids in four handshake phases, %0d results checked",
               grids_sent, sb.checked);
      $display("decoded %0d, border rejects %0d, nonzero distance %0d",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
src/mhd_pkg.sv
src/mhd_row_dist.sv
src/marker_id_hamming_decode.sv
src/mhd_checker.sv
sim/tb.sv
